FILE: hw/rtl/sfq_pkg.sv
`default_nettype none
// ============================================================================
// sfq_pkg
// Shared types and constants for the bounded search queue.
// ============================================================================
package sfq_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 5;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [WORD_W-1:0] DATA_UNDERFLOW = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic                     found;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sfq_ram.sv
`default_nettype none
// ============================================================================
// sfq_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module sfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sfq_ctrl.sv
`default_nettype none
// ============================================================================
// sfq_ctrl
// Sequencer for the queue: keeps head and count, drives the entry memory,
// scans it for searches and parks a finished result while the output is full.
// ============================================================================
module sfq_ctrl
    import sfq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire logic [CAP_W-1:0]         capacity,
    input  wire logic                     out_free,
    output logic                          res_valid,
    output res_t                          res,
    output ram_req_t                      ram_req,
    input  wire logic [WORD_W-1:0]        ram_rdata
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic              found_reg, found_next;
    logic [WORD_W-1:0] value_reg, value_next;
    res_t              pend_reg, pend_next;

    logic              accept;
    logic              fin;
    res_t              fin_res;
    logic              hit;
    logic              full;
    logic [CMP_W-1:0]  eff_cap;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W:0]   tail_sum;
    logic [ADDR_W:0]   scan_sum;
    logic [ADDR_W-1:0] tail_addr;
    logic [ADDR_W-1:0] scan_addr;

    always_comb
    begin
        eff_cap = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
        full    = (CMP_W'(count_reg) >= eff_cap);

        head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);

        tail_sum  = {1'b0, head_reg} + (ADDR_W + 1)'(count_reg);
        tail_addr = (tail_sum >= (ADDR_W + 1)'(DEPTH))
                    ? ADDR_W'(tail_sum - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(tail_sum);

        scan_sum  = {1'b0, head_reg} + (ADDR_W + 1)'(scan_reg);
        scan_addr = (scan_sum >= (ADDR_W + 1)'(DEPTH))
                    ? ADDR_W'(scan_sum - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(scan_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        found_reg <= found_next;
        value_reg <= value_next;
        pend_reg  <= pend_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = 1'b0;
        found_next    = found_reg;
        value_next    = value_reg;
        pend_next     = pend_reg;

        in_stall = (state_reg != S_IDLE);
        accept   = in_valid && !in_stall;
        hit      = rd_valid_reg && (ram_rdata == value_reg);

        ram_req.we    = 1'b0;
        ram_req.waddr = tail_addr;
        ram_req.wdata = value;
        ram_req.raddr = head_reg;

        fin            = 1'b0;
        fin_res.data   = '0;
        fin_res.found  = 1'b0;
        fin_res.status = ST_OK;
        fin_res.count  = '0;

        res_valid = 1'b0;
        res       = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = value;
                    case (operation)
                        OP_ENQUEUE:
                        begin
                            fin = 1'b1;
                            if (full)
                            begin
                                fin_res.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_req.we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin            = 1'b1;
                                fin_res.data   = DATA_UNDERFLOW;
                                fin_res.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_READ;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                scan_next     = CNT_W'(1);
                                rd_valid_next = 1'b1;
                                rd_last_next  = (count_reg == CNT_W'(1));
                                found_next    = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                fin          = 1'b1;
                fin_res.data = ram_rdata;
            end
            S_SCAN:
            begin
                ram_req.raddr = scan_addr;
                found_next    = found_reg || hit;
                if (scan_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_last_next  = (scan_reg == count_reg - CNT_W'(1));
                    scan_next     = scan_reg + CNT_W'(1);
                end
                if (rd_valid_reg && rd_last_reg)
                begin
                    fin           = 1'b1;
                    fin_res.found = found_reg || hit;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    res        = pend_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fin_res.count = COUNT_W'(count_next);

        if (fin)
        begin
            if (out_free)
            begin
                res_valid  = 1'b1;
                res        = fin_res;
                state_next = S_IDLE;
            end
            else
            begin
                pend_next  = fin_res;
                state_next = S_HOLD;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stored count exceeds the queue depth");

    a_park_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && !out_free) |=> (state_reg == S_HOLD))
        else $error("finished item was not parked while the output was full");

    a_read_from_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(accept && (operation == OP_DEQUEUE)))
        else $error("read wait entered without an accepted dequeue");

    a_hold_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && !out_free) |-> !res_valid)
        else $error("parked result released into a full output register");

    a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && $past(state_reg == S_SCAN)) |-> $stable(count_reg))
        else $error("stored count changed during a search");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/shifting_fifo_queue_with_search_top.sv
`default_nettype none
// ============================================================================
// shifting_fifo_queue_with_search_top
// Bounded first-in first-out queue of signed words with search by value.
// ============================================================================
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------
//  in       in_valid / in_stall     operation, value
//  out      out_valid / out_stall   data, found, status, count
//  cfg      cfg_wr_en               cfg_wr_data (capacity)
//
//  Enqueue, rejected operations and a search of an empty queue finish
//  from the idle state; a dequeue passes through a read-wait state for the
//  registered read of the head word. A search walks the entry memory
//  through its single read port, one word per cycle.
//  Reset empties the queue and sets the capacity to 16; the memory is not
//  cleared, since only written words are ever read.
//  While the output register holds an untaken result, one more item is
//  accepted and processed; its result waits until the register frees.
//
module shifting_fifo_queue_with_search_top
    import sfq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [WORD_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [WORD_W-1:0]      data,
    output logic                          found,
    output logic [STATUS_W-1:0]           status,
    output logic [COUNT_W-1:0]            count,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CAP_W-1:0]         cfg_wr_data
);

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic              out_free;
    logic              res_valid;
    res_t              res;
    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = out_reg.data;
    assign found     = out_reg.found;
    assign status    = out_reg.status;
    assign count     = out_reg.count;

    sfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .capacity  (cap_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    sfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire
